// ===== rtl/core/tdr_pkg.sv =====
// tdr_pkg: shared widths, operation and route codes, and the
// controller-to-datapath command struct for the dispatch registry.
// Depends on nothing.
`default_nettype none

package tdr_pkg;

  // field widths
  localparam int KIND_W  = 3;
  localparam int ADDR_W  = 48;
  localparam int SIG_W   = 64;
  localparam int ROUTE_W = 2;

  // default table depth
  localparam int TDR_TABLE_ENTRIES = 16;

  // operation codes
  localparam logic [KIND_W-1:0] OP_ADD      = 3'd0;
  localparam logic [KIND_W-1:0] OP_DISPATCH = 3'd1;
  localparam logic [KIND_W-1:0] OP_ERASE    = 3'd2;
  localparam logic [KIND_W-1:0] OP_TOMB     = 3'd3;
  localparam logic [KIND_W-1:0] OP_GET      = 3'd4;

  // dispatch route codes
  localparam logic [ROUTE_W-1:0] ROUTE_GUEST    = 2'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_REJECT   = 2'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_FRONTEND = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // search, update the table and load the result
  } tdr_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/tdr_ctrl.sv =====
// tdr_ctrl: two-state controller that sequences one transaction at a time
// and drives the result strobe. Depends on tdr_pkg.
`default_nettype none

module tdr_ctrl
  import tdr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output tdr_cmd_t      cmd,
  output logic          out_valid
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd.load = start && (state_r == ST_IDLE);
    cmd.exec = (state_r == ST_EXEC);
  end

  // state and strobe registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.exec;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/tdr_datapath.sv =====
// tdr_datapath: slot storage, parallel key and target compare, table update
// and result registers. Depends on tdr_pkg.
`default_nettype none

module tdr_datapath
  import tdr_pkg::*;
#(
  parameter int TABLE_ENTRIES = TDR_TABLE_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tdr_cmd_t           cmd,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [ADDR_W-1:0]  in_host_key,
  input  wire logic [ADDR_W-1:0]  in_guest_target,
  input  wire logic [SIG_W-1:0]   in_call_signature,
  output logic                    out_accepted,
  output logic                    out_table_full,
  output logic [ROUTE_W-1:0]      out_route,
  output logic [ADDR_W-1:0]       out_route_address,
  output logic                    out_present,
  output logic                    out_retired,
  output logic [ADDR_W-1:0]       out_stored_target,
  output logic [SIG_W-1:0]        out_stored_signature
);

  localparam int N = TABLE_ENTRIES;

  // captured transaction
  logic [KIND_W-1:0] kind_r;
  logic [ADDR_W-1:0] key_r;
  logic [ADDR_W-1:0] tgt_r;
  logic [SIG_W-1:0]  sig_r;

  // slot state
  logic [N-1:0]      used_r, used_nxt;
  logic [N-1:0]      retired_r, retired_nxt;
  logic [ADDR_W-1:0] key_mem_r [N];
  logic [ADDR_W-1:0] target_mem_r [N];
  logic [SIG_W-1:0]  sig_mem_r [N];

  // search results
  logic [N-1:0]      key_hit, key_first, free_first, tgt_hit;
  logic              any_key, any_free;
  logic              sel_retired;
  logic [ADDR_W-1:0] sel_target;
  logic [SIG_W-1:0]  sel_sig;

  // slot write enables
  logic [N-1:0]      wr_key, wr_bind, clr_target;

  // result next values
  logic               accepted_nxt, table_full_nxt, present_nxt, retired_out_nxt;
  logic [ROUTE_W-1:0] route_nxt;
  logic [ADDR_W-1:0]  route_addr_nxt, stored_target_nxt;
  logic [SIG_W-1:0]   stored_sig_nxt;

  // result registers
  logic               accepted_r, table_full_r, present_r, retired_out_r;
  logic [ROUTE_W-1:0] route_r;
  logic [ADDR_W-1:0]  route_addr_r, stored_target_r;
  logic [SIG_W-1:0]   stored_sig_r;

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      key_r  <= in_host_key;
      tgt_r  <= in_guest_target;
      sig_r  <= in_call_signature;
    end
  end

  // parallel compare against every slot
  always_comb begin
    for (int i = 0; i < N; i++) begin
      key_hit[i] = used_r[i] && (key_mem_r[i] == key_r);
      tgt_hit[i] = used_r[i] && !retired_r[i] && (target_mem_r[i] == tgt_r);
    end
  end

  // lowest-index hit and free slot, one-hot
  assign key_first  = key_hit & (~key_hit + N'(1));
  assign free_first = ~used_r & (used_r + N'(1));
  assign any_key    = |key_hit;
  assign any_free   = ~&used_r;

  // read out the found slot
  always_comb begin
    sel_retired = 1'b0;
    sel_target  = '0;
    sel_sig     = '0;
    for (int i = 0; i < N; i++) begin
      sel_retired = sel_retired | (key_first[i] & retired_r[i]);
      sel_target  = sel_target | ({ADDR_W{key_first[i]}} & target_mem_r[i]);
      sel_sig     = sel_sig | ({SIG_W{key_first[i]}} & sig_mem_r[i]);
    end
  end

  // operation decode: table update and result
  always_comb begin
    used_nxt          = used_r;
    retired_nxt       = retired_r;
    wr_key            = '0;
    wr_bind           = '0;
    clr_target        = '0;
    accepted_nxt      = 1'b0;
    table_full_nxt    = 1'b0;
    route_nxt         = ROUTE_GUEST;
    route_addr_nxt    = '0;
    present_nxt       = 1'b0;
    retired_out_nxt   = 1'b0;
    stored_target_nxt = '0;
    stored_sig_nxt    = '0;
    case (kind_r)
      OP_ADD: begin
        if (!any_key) begin
          if (any_free) begin
            used_nxt     = used_r | free_first;
            retired_nxt  = retired_r & ~free_first;
            wr_key       = free_first;
            wr_bind      = free_first;
            accepted_nxt = 1'b1;
          end else begin
            table_full_nxt = 1'b1;
          end
        end else if (sel_retired) begin
          // rebind a tombstoned key
          retired_nxt  = retired_r & ~key_first;
          wr_bind      = key_first;
          accepted_nxt = 1'b1;
        end else begin
          accepted_nxt = (sel_target == tgt_r);
        end
      end
      OP_DISPATCH: begin
        if (!any_key) begin
          route_nxt      = ROUTE_FRONTEND;
          route_addr_nxt = key_r;
        end else if (sel_retired) begin
          route_nxt = ROUTE_REJECT;
        end else begin
          route_nxt      = ROUTE_GUEST;
          route_addr_nxt = sel_target;
        end
      end
      OP_ERASE: begin
        used_nxt = used_r & ~tgt_hit;
      end
      OP_TOMB: begin
        retired_nxt = retired_r | tgt_hit;
        clr_target  = tgt_hit;
      end
      OP_GET: begin
        if (any_key) begin
          present_nxt       = 1'b1;
          retired_out_nxt   = sel_retired;
          stored_target_nxt = sel_target;
          stored_sig_nxt    = sel_sig;
        end
      end
      default: begin
      end
    endcase
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      retired_r <= '0;
    end else if (cmd.exec) begin
      used_r    <= used_nxt;
      retired_r <= retired_nxt;
    end
  end

  // slot payload storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (cmd.exec && wr_key[i]) key_mem_r[i] <= key_r;
      if (cmd.exec && wr_bind[i]) begin
        target_mem_r[i] <= tgt_r;
        sig_mem_r[i]    <= sig_r;
      end else if (cmd.exec && clr_target[i]) begin
        target_mem_r[i] <= '0;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      accepted_r      <= accepted_nxt;
      table_full_r    <= table_full_nxt;
      route_r         <= route_nxt;
      route_addr_r    <= route_addr_nxt;
      present_r       <= present_nxt;
      retired_out_r   <= retired_out_nxt;
      stored_target_r <= stored_target_nxt;
      stored_sig_r    <= stored_sig_nxt;
    end
  end

  assign out_accepted         = accepted_r;
  assign out_table_full       = table_full_r;
  assign out_route            = route_r;
  assign out_route_address    = route_addr_r;
  assign out_present          = present_r;
  assign out_retired          = retired_out_r;
  assign out_stored_target    = stored_target_r;
  assign out_stored_signature = stored_sig_r;

endmodule

`default_nettype wire

// ===== rtl/core/tombstoning_dispatch_registry_unit.sv =====
// Tombstoning dispatch registry, top level: a command-style port in front of
// an associative table of host keys. Each transaction accepted while busy is
// low passes through the accept cycle and the execute cycle, in which all
// slots are compared in parallel, the table is updated and the result is
// registered. The result is shown from those registers for exactly one cycle
// with out_valid; the receiver cannot stall it. busy is low again in the cycle
// the result shows, so a new transaction can be taken then, not before.
// The slot flags reset to empty; there is no clearing pass after reset.
// Depends on tdr_pkg, tdr_ctrl and tdr_datapath.
`default_nettype none

module tombstoning_dispatch_registry_unit
  import tdr_pkg::*;
#(
  parameter int TABLE_ENTRIES = TDR_TABLE_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [ADDR_W-1:0]  in_host_key,
  input  wire logic [ADDR_W-1:0]  in_guest_target,
  input  wire logic [SIG_W-1:0]   in_call_signature,
  output logic                    out_valid,
  output logic                    out_accepted,
  output logic                    out_table_full,
  output logic [ROUTE_W-1:0]      out_route,
  output logic [ADDR_W-1:0]       out_route_address,
  output logic                    out_present,
  output logic                    out_retired,
  output logic [ADDR_W-1:0]       out_stored_target,
  output logic [SIG_W-1:0]        out_stored_signature
);

  tdr_cmd_t cmd;

  // sequencing
  tdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // table and result datapath
  tdr_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_kind              (in_kind),
    .in_host_key          (in_host_key),
    .in_guest_target      (in_guest_target),
    .in_call_signature    (in_call_signature),
    .out_accepted         (out_accepted),
    .out_table_full       (out_table_full),
    .out_route            (out_route),
    .out_route_address    (out_route_address),
    .out_present          (out_present),
    .out_retired          (out_retired),
    .out_stored_target    (out_stored_target),
    .out_stored_signature (out_stored_signature)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tdr_checker.sv =====
// tdr_checker: port-level assertions on transaction timing and result
// consistency, bound to the registry top level. Depends on tdr_pkg.
`default_nettype none

module tdr_checker
  import tdr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic               out_accepted,
  input wire logic               out_table_full,
  input wire logic [ROUTE_W-1:0] out_route,
  input wire logic               out_present,
  input wire logic               out_retired
);

  // an accepted transaction makes the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // every accepted transaction gives its result strobe once it has executed
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result strobe missing two cycles after accept");

  // results never come in adjacent cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a full table never also reports acceptance
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> !out_accepted)
    else $error("table_full and accepted both set");

  // tombstone flag only with a found entry; no unused route code
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_present || !out_retired) && (out_route != 2'd3)))
    else $error("inconsistent result fields");

endmodule

bind tombstoning_dispatch_registry_unit tdr_checker u_tdr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_accepted   (out_accepted),
  .out_table_full (out_table_full),
  .out_route      (out_route),
  .out_present    (out_present),
  .out_retired    (out_retired)
);

`default_nettype wire
